FILE: hdl/agm_pkg.sv
// Package for the adaptive-gain audio mixer: widths, gain constants,
// controller state encoding and the divider status bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package agm_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned NUM_INPUTS = 10;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned QUOT_W     = 16;

  localparam logic [CFG_W-1:0]    SRC_COUNT_RST = 4'd2;
  localparam logic [GAIN_W-1:0]   GAIN_ONE      = 17'h10000;
  localparam int unsigned         RECOVER_SHIFT = 5;
  localparam logic [SAMPLE_W-1:0] OUT_MAX_MAG   = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] OUT_MIN_MAG   = 16'h8000;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_CHK  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } agm_state_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_status_t;

endpackage

`default_nettype wire

FILE: hdl/agm_if.sv
// Channel interfaces of the mixer: input beat with ten samples and
// result beat with one mixed sample. Depends on agm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface agm_in_if
  import agm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_0;
  logic signed [SAMPLE_W-1:0] sample_1;
  logic signed [SAMPLE_W-1:0] sample_2;
  logic signed [SAMPLE_W-1:0] sample_3;
  logic signed [SAMPLE_W-1:0] sample_4;
  logic signed [SAMPLE_W-1:0] sample_5;
  logic signed [SAMPLE_W-1:0] sample_6;
  logic signed [SAMPLE_W-1:0] sample_7;
  logic signed [SAMPLE_W-1:0] sample_8;
  logic signed [SAMPLE_W-1:0] sample_9;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8, sample_9,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4,
           sample_5, sample_6, sample_7, sample_8, sample_9,
    output ready
  );
endinterface

interface agm_out_if
  import agm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;

  modport source (output valid, mixed_sample, input ready);
  modport sink (input valid, mixed_sample, output ready);
endinterface

`default_nettype wire

FILE: hdl/adaptive_gain_audio_mixer.sv
// Top level of the adaptive-gain audio mixer: source lanes, merge stage,
// gain multiplier, clamp divider and controller.
// Depends on agm_pkg, agm_if, agm_lane, agm_merge and agm_div.
//
//   port      dir   beat contents
//   in_bus    sink  sample_0 .. sample_9, signed 16 bit each
//   out_bus   src   mixed_sample, signed 16 bit
//   cfg_*     in    source_count (4 bit), written when cfg_we is high
//
// After the accepting edge the beat passes the lane registers, merge register,
// scaled product and clamp check, then the result register loads in the final
// state; when it clamps, the serial divider first computes the new gain and
// hands it over. One item is in work at a time; the next beat is taken once
// the controller is back in idle. A stalled output holds the controller in its final state.
// Synchronous reset sets unity gain and frame position zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_gain_audio_mixer
  import agm_pkg::*;
#(
  parameter int unsigned FRAME_SAMPLES = 512,
  parameter int unsigned MAX_SOURCES   = 10
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  agm_in_if.sink                in_bus,
  agm_out_if.source             out_bus,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned SUM_W  = SAMPLE_W + $clog2(MAX_SOURCES);
  localparam int unsigned SC_W   = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + GAIN_W;
  localparam int unsigned POS_W  = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

  agm_state_t state_r, state_nxt;

  logic [CFG_W-1:0]           src_count_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [POS_W-1:0]           pos_r;
  logic [SC_W-1:0]            scaled_r;
  logic [SAMPLE_W-1:0]        res_r;
  logic [SAMPLE_W-1:0]        out_data_r;
  logic                       out_valid_r;

  logic signed [SAMPLE_W-1:0] smp     [NUM_INPUTS];
  logic signed [SAMPLE_W-1:0] lane_q  [MAX_SOURCES];
  logic                       accept;
  logic                       out_free;
  logic                       neg;
  logic [SUM_W-1:0]           mag;
  logic [PROD_W-1:0]          prod;
  logic [SC_W-1:0]            scaled_neg;
  logic                       ovf_pos;
  logic                       ovf_neg;
  logic                       div_start;
  logic [SAMPLE_W-1:0]        div_limit;
  div_status_t                div_st;
  logic [GAIN_W-1:0]          recover;

  assign smp[0] = in_bus.sample_0;
  assign smp[1] = in_bus.sample_1;
  assign smp[2] = in_bus.sample_2;
  assign smp[3] = in_bus.sample_3;
  assign smp[4] = in_bus.sample_4;
  assign smp[5] = in_bus.sample_5;
  assign smp[6] = in_bus.sample_6;
  assign smp[7] = in_bus.sample_7;
  assign smp[8] = in_bus.sample_8;
  assign smp[9] = in_bus.sample_9;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;

  // a count above the lane count simply enables every lane
  for (genvar k = 0; k < MAX_SOURCES; k++) begin : g_lane
    agm_lane u_lane (
      .clk      (clk),
      .load     (accept),
      .active   (CFG_W'(k) < src_count_r),
      .sample_i (smp[k]),
      .lane_q   (lane_q[k])
    );
  end

  agm_merge #(
    .LANES (MAX_SOURCES),
    .SUM_W (SUM_W)
  ) u_merge (
    .clk    (clk),
    .load   (state_r == ST_SUM),
    .lane_q (lane_q),
    .neg_q  (neg),
    .mag_q  (mag)
  );

  assign prod       = PROD_W'(mag) * PROD_W'(gain_r);
  assign scaled_neg = ~scaled_r + 1'b1;
  assign ovf_pos    = !neg && (scaled_r > SC_W'(OUT_MAX_MAG));
  assign ovf_neg    = neg && (scaled_r > SC_W'(OUT_MIN_MAG));
  assign div_start  = (state_r == ST_CHK) && (ovf_pos || ovf_neg);
  assign div_limit  = ovf_pos ? OUT_MAX_MAG : OUT_MIN_MAG;
  assign recover    = (GAIN_ONE - gain_r) >> RECOVER_SHIFT;

  agm_div #(
    .DIV_W (SC_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .limit   (div_limit),
    .divisor (scaled_r),
    .status  (div_st)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = div_start ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_st.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      src_count_r <= SRC_COUNT_RST;
      gain_r      <= GAIN_ONE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        src_count_r <= cfg_wdata;
      end
      if (accept) begin
        if (pos_r == '0) begin
          gain_r <= GAIN_ONE;
        end
        pos_r <= (pos_r == POS_W'(FRAME_SAMPLES - 1)) ? '0 : pos_r + 1'b1;
      end
      if (state_r == ST_DIV && div_st.done) begin
        gain_r <= GAIN_W'(div_st.quotient);
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        if (gain_r < GAIN_ONE) begin
          gain_r <= gain_r + recover;
        end
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      scaled_r <= prod[PROD_W-1:GAIN_W-1];
    end
    if (state_r == ST_CHK) begin
      if (ovf_pos) begin
        res_r <= OUT_MAX_MAG;
      end else if (ovf_neg) begin
        res_r <= OUT_MIN_MAG;
      end else begin
        res_r <= neg ? scaled_neg[SAMPLE_W-1:0] : scaled_r[SAMPLE_W-1:0];
      end
    end
    if (state_r == ST_FIN && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.mixed_sample = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/agm_lane.sv
// One mixer lane: captures its source sample, gated to zero when the
// source is not part of the mix. Depends on agm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agm_lane
  import agm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic                       active,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [SAMPLE_W-1:0]      lane_q
);

  logic signed [SAMPLE_W-1:0] lane_r;

  always_ff @(posedge clk) begin
    if (load) begin
      lane_r <= active ? sample_i : '0;
    end
  end

  assign lane_q = lane_r;

endmodule

`default_nettype wire

FILE: hdl/agm_merge.sv
// Merge stage: adds the lane outputs and registers sign and magnitude
// of the sum. Depends on agm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agm_merge
  import agm_pkg::*;
#(
  parameter int unsigned LANES = 10,
  parameter int unsigned SUM_W = 20
) (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic signed [SAMPLE_W-1:0] lane_q [LANES],
  output logic                            neg_q,
  output logic [SUM_W-1:0]                mag_q
);

  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        mag_c;
  logic                    neg_r;
  logic [SUM_W-1:0]        mag_r;

  always_comb begin
    sum = '0;
    for (int k = 0; k < LANES; k++) begin
      sum = sum + SUM_W'(lane_q[k]);
    end
  end

  // most negative sum still fits as an unsigned magnitude
  assign mag_c = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

  always_ff @(posedge clk) begin
    if (load) begin
      neg_r <= sum[SUM_W-1];
      mag_r <= mag_c;
    end
  end

  assign neg_q = neg_r;
  assign mag_q = mag_r;

endmodule

`default_nettype wire

FILE: hdl/agm_div.sv
// Restoring radix-2 divider for the clamp gain: limit * 65536 / divisor,
// one quotient bit per cycle. Depends on agm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module agm_div
  import agm_pkg::*;
#(
  parameter int unsigned DIV_W = 21
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SAMPLE_W-1:0] limit,
  input  wire logic [DIV_W-1:0]    divisor,
  output div_status_t              status
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W:0]    rem_r;
  logic [DIV_W-1:0]  den_r;
  logic [QUOT_W-1:0] quo_r;
  logic [DIV_W:0]    shifted;
  logic              fits;

  // limit < divisor, so the quotient has only the low 16 bits set
  assign shifted = {rem_r[DIV_W-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (DIV_W + 1)'(limit);
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? (shifted - {1'b0, den_r}) : shifted;
      quo_r <= {quo_r[QUOT_W-2:0], fits};
    end
  end

  assign status.done     = done_r;
  assign status.quotient = quo_r;

endmodule

`default_nettype wire
